FILE: hdl/clle_pkg.sv
// ----------------------------------------------------------------------------
// clle_pkg
// Shared types and constants for the cursor linked list engine.
// ----------------------------------------------------------------------------
package clle_pkg;

    localparam int ACT_W  = 3;
    localparam int POS_W  = 5;
    localparam int ITEM_W = 32;
    localparam int IDX_W  = 4;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_ERASE  = 3'd1,
        ACT_GET    = 3'd2,
        ACT_FIND   = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WALK,
        ST_INS_LINK,
        ST_ERASE_FIX,
        ST_FIND,
        ST_DONE
    } state_t;

    // slot table port strobes
    typedef struct packed {
        logic rd;
        logic wr;
    } ram_ctl_t;

    // slot allocator commands
    typedef struct packed {
        logic take;
        logic free_one;
        logic wipe;
    } alloc_cmd_t;

endpackage

FILE: hdl/cursor_linked_list_engine.sv
// ----------------------------------------------------------------------------
// cursor_linked_list_engine
// Singly linked list kept in a slot table with lowest-free-slot allocation.
// ----------------------------------------------------------------------------
// Clear, rejects and insert at the head need no walk; get, insert and erase
//   walk to the position; find walks to the match, or the whole list on a miss.
// One transaction at a time; the next is taken only after the result is
//   registered. The walk costs one slot table read per link.
// Reset (async, active low): list empty, all slots free, capacity 16.
module cursor_linked_list_engine
    import clle_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int ITEM_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACT_W-1:0]    action,
    input  logic [POS_W-1:0]    position,
    input  logic [ITEM_W-1:0]   item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                ok,
    output logic [ITEM_W-1:0]   item_out,
    output logic [IDX_W-1:0]    found_index,
    output logic [CAP_W-1:0]    count,
    output logic                is_empty,
    output logic                is_full,
    input  logic                cfg_wr_en,
    input  logic [CAP_W-1:0]    cfg_wr_data
);

    // the 5-bit capacity keeps at most 31 items live, so only the lowest
    // 31 slots are ever allocated
    localparam int ROWS = (SLOTS < (1 << CAP_W)) ? SLOTS : (1 << CAP_W);
    localparam int SW   = $clog2(ROWS);
    localparam int IW   = (ITEM_BITS < ITEM_W) ? ITEM_BITS : ITEM_W;
    localparam int RW   = SW + IW;

    ram_ctl_t       ram_ctl;
    logic [SW-1:0]  ram_rd_addr;
    logic [SW-1:0]  ram_wr_addr;
    logic [RW-1:0]  ram_wr_data;
    logic [RW-1:0]  ram_rd_data;
    alloc_cmd_t     alloc_cmd;
    logic [SW-1:0]  rel_slot;
    logic [SW-1:0]  free_slot;

    clle_ctrl #(
        .ROWS (ROWS),
        .SW   (SW),
        .IW   (IW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .position    (position),
        .item        (item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .item_out    (item_out),
        .found_index (found_index),
        .count       (count),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ram_ctl     (ram_ctl),
        .ram_rd_addr (ram_rd_addr),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_data (ram_rd_data),
        .alloc_cmd   (alloc_cmd),
        .rel_slot    (rel_slot),
        .free_slot   (free_slot)
    );

    clle_slot_ram #(
        .ROWS (ROWS),
        .SW   (SW),
        .RW   (RW)
    ) u_slot_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .rd_addr (ram_rd_addr),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_data (ram_rd_data)
    );

    clle_alloc #(
        .ROWS (ROWS),
        .SW   (SW)
    ) u_alloc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (alloc_cmd),
        .rel_slot  (rel_slot),
        .free_slot (free_slot)
    );

endmodule

FILE: hdl/clle_slot_ram.sv
// ----------------------------------------------------------------------------
// clle_slot_ram
// Slot table: one write port, one read port, registered read data.
// Each row holds {link, item}.
// ----------------------------------------------------------------------------
module clle_slot_ram
    import clle_pkg::*;
#(
    parameter int ROWS = 16,
    parameter int SW   = 4,
    parameter int RW   = 36
)
(
    input  logic          clk,
    input  ram_ctl_t      ctl,
    input  logic [SW-1:0] rd_addr,
    input  logic [SW-1:0] wr_addr,
    input  logic [RW-1:0] wr_data,
    output logic [RW-1:0] rd_data
);

    logic [RW-1:0] mem [ROWS];
    logic [RW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/clle_alloc.sv
// ----------------------------------------------------------------------------
// clle_alloc
// Used marks for the slots and the lowest-free-slot search.
// ----------------------------------------------------------------------------
module clle_alloc
    import clle_pkg::*;
#(
    parameter int ROWS = 16,
    parameter int SW   = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  alloc_cmd_t    cmd,
    input  logic [SW-1:0] rel_slot,
    output logic [SW-1:0] free_slot
);

    logic [ROWS-1:0] used_reg;

    always_comb
    begin
        free_slot = '0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = SW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.wipe)
        begin
            used_reg <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                used_reg[free_slot] <= 1'b1;
            end
            if (cmd.free_one)
            begin
                used_reg[rel_slot] <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // a slot handed out must really be free
    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> !used_reg[free_slot])
        else $error("allocated slot already in use");

    a_wipe_all: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wipe |=> (used_reg == '0))
        else $error("clear left used slots");
`endif

endmodule

FILE: hdl/clle_ctrl.sv
// ----------------------------------------------------------------------------
// clle_ctrl
// Sequencer: decodes the transaction, walks the links through the slot table
// one read per cycle, writes back the relinked rows and holds the result.
// ----------------------------------------------------------------------------
module clle_ctrl
    import clle_pkg::*;
#(
    parameter int ROWS = 16,
    parameter int SW   = 4,
    parameter int IW   = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACT_W-1:0]    action,
    input  logic [POS_W-1:0]    position,
    input  logic [ITEM_W-1:0]   item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                ok,
    output logic [ITEM_W-1:0]   item_out,
    output logic [IDX_W-1:0]    found_index,
    output logic [CAP_W-1:0]    count,
    output logic                is_empty,
    output logic                is_full,
    input  logic                cfg_wr_en,
    input  logic [CAP_W-1:0]    cfg_wr_data,
    output ram_ctl_t            ram_ctl,
    output logic [SW-1:0]       ram_rd_addr,
    output logic [SW-1:0]       ram_wr_addr,
    output logic [SW+IW-1:0]    ram_wr_data,
    input  logic [SW+IW-1:0]    ram_rd_data,
    output alloc_cmd_t          alloc_cmd,
    output logic [SW-1:0]       rel_slot,
    input  logic [SW-1:0]       free_slot
);

    localparam int CAP_LIM = (1 << CAP_W) - 1;
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'((ROWS < CAP_LIM) ? ROWS : CAP_LIM);

    state_t              state_reg, state_next;
    action_t             act_reg, act_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [IW-1:0]       key_reg, key_next;
    logic [CAP_W-1:0]    count_reg, count_next;
    logic [SW-1:0]       head_reg, head_next;
    logic [SW-1:0]       cur_reg, cur_next;
    logic [SW-1:0]       neo_reg, neo_next;
    logic [POS_W-1:0]    remain_reg, remain_next;
    logic [POS_W-1:0]    idx_reg, idx_next;
    logic [IW-1:0]       hold_reg, hold_next;
    logic [CAP_W-1:0]    cap_reg;
    logic [CAP_W-1:0]    cap_eff;

    logic                res_ok_reg, res_ok_next;
    logic [ITEM_W-1:0]   res_item_reg, res_item_next;
    logic [IDX_W-1:0]    res_found_reg, res_found_next;

    logic                out_valid_reg, out_valid_next;
    logic                ok_reg, ok_next;
    logic [ITEM_W-1:0]   item_out_reg, item_out_next;
    logic [IDX_W-1:0]    found_reg, found_next;
    logic [CAP_W-1:0]    cnt_out_reg, cnt_out_next;
    logic                empty_reg, empty_next;
    logic                full_reg, full_next;

    logic [SW-1:0]       rd_link;
    logic [IW-1:0]       rd_item;

    assign rd_link = ram_rd_data[SW+IW-1:IW];
    assign rd_item = ram_rd_data[IW-1:0];

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CAP_W'(1);
        end
        else if (cap_reg > CAP_MAX)
        begin
            cap_eff = CAP_MAX;
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        pos_reg       <= pos_next;
        key_reg       <= key_next;
        head_reg      <= head_next;
        cur_reg       <= cur_next;
        neo_reg       <= neo_next;
        remain_reg    <= remain_next;
        idx_reg       <= idx_next;
        hold_reg      <= hold_next;
        res_ok_reg    <= res_ok_next;
        res_item_reg  <= res_item_next;
        res_found_reg <= res_found_next;
        ok_reg        <= ok_next;
        item_out_reg  <= item_out_next;
        found_reg     <= found_next;
        cnt_out_reg   <= cnt_out_next;
        empty_reg     <= empty_next;
        full_reg      <= full_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        neo_next       = neo_reg;
        remain_next    = remain_reg;
        idx_next       = idx_reg;
        hold_next      = hold_reg;
        res_ok_next    = res_ok_reg;
        res_item_next  = res_item_reg;
        res_found_next = res_found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ok_next        = ok_reg;
        item_out_next  = item_out_reg;
        found_next     = found_reg;
        cnt_out_next   = cnt_out_reg;
        empty_next     = empty_reg;
        full_next      = full_reg;

        in_ready       = 1'b0;
        ram_ctl        = '0;
        ram_rd_addr    = head_reg;
        ram_wr_addr    = cur_reg;
        ram_wr_data    = {rd_link, key_reg};
        alloc_cmd      = '0;
        rel_slot       = cur_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    act_next   = action_t'(action);
                    pos_next   = position;
                    key_next   = item[IW-1:0];
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                res_ok_next    = 1'b0;
                res_item_next  = '0;
                res_found_next = '0;
                cur_next       = head_reg;
                state_next     = ST_DONE;
                case (act_reg)
                    ACT_INSERT:
                    begin
                        if (pos_reg <= count_reg && count_reg < cap_eff)
                        begin
                            if (pos_reg == '0)
                            begin
                                ram_ctl.wr      = 1'b1;
                                ram_wr_addr     = free_slot;
                                ram_wr_data     = {head_reg, key_reg};
                                alloc_cmd.take  = 1'b1;
                                head_next       = free_slot;
                                count_next      = count_reg + CAP_W'(1);
                                res_ok_next     = 1'b1;
                            end
                            else
                            begin
                                ram_ctl.rd  = 1'b1;
                                remain_next = pos_reg - POS_W'(1);
                                state_next  = ST_WALK;
                            end
                        end
                    end
                    ACT_ERASE:
                    begin
                        if (pos_reg < count_reg)
                        begin
                            ram_ctl.rd  = 1'b1;
                            remain_next = (pos_reg == '0) ? '0 : pos_reg - POS_W'(1);
                            state_next  = ST_WALK;
                        end
                    end
                    ACT_GET:
                    begin
                        if (pos_reg < count_reg)
                        begin
                            ram_ctl.rd  = 1'b1;
                            remain_next = pos_reg;
                            state_next  = ST_WALK;
                        end
                    end
                    ACT_FIND:
                    begin
                        if (count_reg != '0)
                        begin
                            ram_ctl.rd = 1'b1;
                            idx_next   = '0;
                            state_next = ST_FIND;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        alloc_cmd.wipe = 1'b1;
                        count_next     = '0;
                        res_ok_next    = 1'b1;
                    end
                    default:
                    begin
                        res_ok_next = 1'b0;
                    end
                endcase
            end

            // read data holds the row of cur_reg
            ST_WALK:
            begin
                if (remain_reg != '0)
                begin
                    ram_ctl.rd  = 1'b1;
                    ram_rd_addr = rd_link;
                    cur_next    = rd_link;
                    remain_next = remain_reg - POS_W'(1);
                end
                else
                begin
                    state_next = ST_DONE;
                    case (act_reg)
                        ACT_GET:
                        begin
                            res_ok_next   = 1'b1;
                            res_item_next = ITEM_W'(rd_item);
                        end
                        ACT_INSERT:
                        begin
                            // new row takes over the predecessor's link
                            ram_ctl.wr     = 1'b1;
                            ram_wr_addr    = free_slot;
                            ram_wr_data    = {rd_link, key_reg};
                            alloc_cmd.take = 1'b1;
                            neo_next       = free_slot;
                            count_next     = count_reg + CAP_W'(1);
                            res_ok_next    = 1'b1;
                            state_next     = ST_INS_LINK;
                        end
                        ACT_ERASE:
                        begin
                            if (pos_reg == '0)
                            begin
                                head_next          = rd_link;
                                alloc_cmd.free_one = 1'b1;
                                count_next         = count_reg - CAP_W'(1);
                                res_ok_next        = 1'b1;
                                res_item_next      = ITEM_W'(rd_item);
                            end
                            else
                            begin
                                ram_ctl.rd  = 1'b1;
                                ram_rd_addr = rd_link;
                                neo_next    = rd_link;
                                hold_next   = rd_item;
                                state_next  = ST_ERASE_FIX;
                            end
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end

            // predecessor row still in read data: point it at the new row
            ST_INS_LINK:
            begin
                ram_ctl.wr  = 1'b1;
                ram_wr_addr = cur_reg;
                ram_wr_data = {neo_reg, rd_item};
                state_next  = ST_DONE;
            end

            // victim row in read data: bypass it
            ST_ERASE_FIX:
            begin
                ram_ctl.wr         = 1'b1;
                ram_wr_addr        = cur_reg;
                ram_wr_data        = {rd_link, hold_reg};
                alloc_cmd.free_one = 1'b1;
                rel_slot           = neo_reg;
                count_next         = count_reg - CAP_W'(1);
                res_ok_next        = 1'b1;
                res_item_next      = ITEM_W'(rd_item);
                state_next         = ST_DONE;
            end

            ST_FIND:
            begin
                if (rd_item == key_reg)
                begin
                    res_ok_next    = 1'b1;
                    res_found_next = idx_reg[IDX_W-1:0];
                    state_next     = ST_DONE;
                end
                else if (idx_reg + POS_W'(1) == count_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_ctl.rd  = 1'b1;
                    ram_rd_addr = rd_link;
                    idx_next    = idx_reg + POS_W'(1);
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = res_ok_reg;
                    item_out_next  = res_item_reg;
                    found_next     = res_found_reg;
                    cnt_out_next   = count_reg;
                    empty_next     = (count_reg == '0);
                    full_next      = (count_reg >= cap_eff);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign item_out    = item_out_reg;
    assign found_index = found_reg;
    assign count       = cnt_out_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;

`ifndef NO_ASSERTIONS
    // the sequencer never reads and writes the table in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_ctl.rd && ram_ctl.wr))
        else $error("slot table read and write overlap");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_MAX)
        else $error("item count beyond table size");

    a_done_hands_off: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_valid_reg || out_ready))
        |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (empty_reg == (cnt_out_reg == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cursor linked list engine. A predictor mirrors
// the slot table, links, head and count, and queues one expected response per
// accepted request. Directed requests hit the empty, tail and reject cases,
// then random phases sweep the capacity register while either side may throttle.
// ----------------------------------------------------------------------------
module tb
    import clle_pkg::*;
();

    localparam int NUM_SLOTS   = 16;
    localparam int EMPTY_HEAD  = NUM_SLOTS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 11;
    localparam int PHASE_REQS  = 170;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [ACT_W-1:0]    action;
    logic [POS_W-1:0]    position;
    logic [ITEM_W-1:0]   item;
    logic                out_valid;
    logic                out_ready;
    logic                ok;
    logic [ITEM_W-1:0]   item_out;
    logic [IDX_W-1:0]    found_index;
    logic [CAP_W-1:0]    count;
    logic                is_empty;
    logic                is_full;
    logic                cfg_wr_en;
    logic [CAP_W-1:0]    cfg_wr_data;

    int send_gap_pct;
    int stall_pct;
    int cycle_count;

    typedef struct {
        logic                ok;
        logic [ITEM_W-1:0]   item_out;
        logic [IDX_W-1:0]    found_index;
        logic [CAP_W-1:0]    count;
        logic                is_empty;
        logic                is_full;
    } list_reply_t;

    // Mirror of the list plus the queue of replies it has predicted.
    class list_scoreboard;
        logic [ITEM_W-1:0]  slot_item [NUM_SLOTS];
        logic [IDX_W-1:0]   slot_link [NUM_SLOTS];
        bit                 slot_end  [NUM_SLOTS];
        bit                 slot_used [NUM_SLOTS];
        int                 head;
        int                 item_count;
        logic [CAP_W-1:0]   capacity;
        list_reply_t        pending_replies[$];
        int                 errors;
        int                 replies_checked;
        int                 done_ok [8];
        int                 done_rejected [8];

        function new();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_item[i] = '0;
                slot_link[i] = '0;
                slot_end[i]  = 1'b0;
                slot_used[i] = 1'b0;
            end
            head       = EMPTY_HEAD;
            item_count = 0;
            capacity   = CAP_RESET;
            errors     = 0;
            replies_checked = 0;
            for (int i = 0; i < 8; i++)
            begin
                done_ok[i]       = 0;
                done_rejected[i] = 0;
            end
        endfunction

        function int head_slot_safe();
            return (head < NUM_SLOTS) ? head : 0;
        endfunction

        function int limit_in_effect();
            if (capacity == 0)
                return 1;
            if (capacity > NUM_SLOTS)
                return NUM_SLOTS;
            return int'(capacity);
        endfunction

        function int slot_after(int steps);
            int s;
            s = head_slot_safe();
            for (int i = 0; i < steps; i++)
                s = int'(slot_link[s]);
            return s;
        endfunction

        function logic [ITEM_W-1:0] item_at(int pos);
            return slot_item[slot_after(pos)];
        endfunction

        function void note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                   logic [ITEM_W-1:0] value);
            list_reply_t r;
            int          cap;
            int          fresh;
            int          prev;
            int          victim;
            int          s;
            r.ok          = 1'b0;
            r.item_out    = '0;
            r.found_index = '0;
            cap = limit_in_effect();
            case (act)
                ACT_INSERT:
                begin
                    if (pos <= item_count && item_count < cap)
                    begin
                        fresh = 0;
                        while (slot_used[fresh])
                            fresh++;
                        slot_item[fresh] = value;
                        slot_used[fresh] = 1'b1;
                        if (pos == 0)
                        begin
                            slot_link[fresh] = (item_count == 0) ? '0
                                                                 : IDX_W'(head_slot_safe());
                            slot_end[fresh]  = (item_count == 0);
                            head = fresh;
                        end
                        else
                        begin
                            prev = slot_after(pos - 1);
                            slot_link[fresh] = slot_link[prev];
                            slot_end[fresh]  = slot_end[prev];
                            slot_link[prev]  = IDX_W'(fresh);
                            slot_end[prev]   = 1'b0;
                        end
                        item_count++;
                        r.ok = 1'b1;
                    end
                end
                ACT_ERASE:
                begin
                    if (pos < item_count)
                    begin
                        if (pos == 0)
                        begin
                            victim = head_slot_safe();
                            head = slot_end[victim] ? EMPTY_HEAD : int'(slot_link[victim]);
                        end
                        else
                        begin
                            // unlink by following links, never by slot number
                            prev = slot_after(pos - 1);
                            victim = int'(slot_link[prev]);
                            slot_link[prev] = slot_link[victim];
                            slot_end[prev]  = slot_end[victim];
                        end
                        r.item_out = slot_item[victim];
                        slot_used[victim] = 1'b0;
                        item_count--;
                        if (item_count == 0)
                            head = EMPTY_HEAD;
                        r.ok = 1'b1;
                    end
                end
                ACT_GET:
                begin
                    if (pos < item_count)
                    begin
                        r.item_out = item_at(pos);
                        r.ok = 1'b1;
                    end
                end
                ACT_FIND:
                begin
                    s = head_slot_safe();
                    for (int i = 0; i < item_count; i++)
                    begin
                        if (slot_item[s] == value)
                        begin
                            r.ok = 1'b1;
                            r.found_index = i[IDX_W-1:0];
                            break;
                        end
                        s = int'(slot_link[s]);
                    end
                end
                ACT_CLEAR:
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                        slot_used[i] = 1'b0;
                    head = EMPTY_HEAD;
                    item_count = 0;
                    r.ok = 1'b1;
                end
                default:
                begin
                end
            endcase
            r.count    = item_count[CAP_W-1:0];
            r.is_empty = (item_count == 0);
            r.is_full  = (item_count >= cap);
            if (r.ok)
                done_ok[act]++;
            else
                done_rejected[act]++;
            pending_replies.push_back(r);
        endfunction

        function bit field_matches(string name, logic [ITEM_W-1:0] want,
                                   logic [ITEM_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t ns: mismatch on %s, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_reply(list_reply_t got);
            list_reply_t want;
            bit          good;
            if (pending_replies.size() == 0)
            begin
                $display("%0t ns: response with no transaction outstanding", $time);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            good = 1'b1;
            good &= field_matches("ok",          want.ok,          got.ok);
            good &= field_matches("item_out",    want.item_out,    got.item_out);
            good &= field_matches("found_index", want.found_index, got.found_index);
            good &= field_matches("count",       want.count,       got.count);
            good &= field_matches("is_empty",    want.is_empty,    got.is_empty);
            good &= field_matches("is_full",     want.is_full,     got.is_full);
            if (!good)
                errors++;
            replies_checked++;
        endfunction
    endclass

    list_scoreboard board;

    cursor_linked_list_engine i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .position    (position),
        .item        (item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .item_out    (item_out),
        .found_index (found_index),
        .count       (count),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // response side: random stall bursts, none while stall_pct is zero
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        list_reply_t got;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            got.ok          = ok;
            got.item_out    = item_out;
            got.found_index = found_index;
            got.count       = count;
            got.is_empty    = is_empty;
            got.is_full     = is_full;
            board.check_reply(got);
        end
    end

    task automatic send_request(input logic [ACT_W-1:0] act, input int pos,
                                input logic [ITEM_W-1:0] value);
        in_valid <= 1'b1;
        action   <= act;
        position <= pos[POS_W-1:0];
        item     <= value;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        board.note_request(act, pos[POS_W-1:0], value);
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input int value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[CAP_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.capacity = value[CAP_W-1:0];
    endtask

    // small values give duplicates, so find has to return the first match
    function automatic logic [ITEM_W-1:0] any_item();
        return ($urandom_range(0, 3) == 0) ? ITEM_W'($urandom_range(0, 7)) : $urandom;
    endfunction

    task automatic send_random(input int insert_pct);
        int                 pick;
        int                 n;
        logic [ITEM_W-1:0]  value;
        pick  = $urandom_range(0, 99);
        n     = board.item_count;
        value = any_item();
        if (pick < insert_pct)
            send_request(ACT_INSERT, $urandom_range(0, n), value);
        else if (pick < insert_pct + 18)
            send_request(ACT_ERASE, (n > 0) ? $urandom_range(0, n - 1) : 0, value);
        else if (pick < insert_pct + 32)
            send_request(ACT_GET, (n > 0) ? $urandom_range(0, n - 1) : 0, value);
        else if (pick < insert_pct + 46)
        begin
            if (n > 0 && $urandom_range(0, 2) != 0)
                value = board.item_at($urandom_range(0, n - 1));
            send_request(ACT_FIND, $urandom_range(0, 31), value);
        end
        else if (pick < insert_pct + 48)
            send_request(ACT_CLEAR, $urandom_range(0, 31), value);
        else
            // bad positions, unknown actions, random fields
            send_request(ACT_W'($urandom_range(0, 7)), $urandom_range(0, 31), $urandom);
    endtask

    initial
    begin
        int phase_cap    [NUM_PHASES];
        int phase_insert [NUM_PHASES];
        int phase_gap    [NUM_PHASES];
        int phase_stall  [NUM_PHASES];
        phase_cap    = '{16, 1, 0, 31, 17, 16, 3, 16, 9, 2, 16};
        phase_insert = '{30, 40, 30, 40, 45, 50, 20, 30, 40, 30, 35};
        phase_gap    = '{0, 20, 35, 10, 0, 25, 15, 40, 5, 20, 0};
        phase_stall  = '{10, 0, 15, 5, 20, 0, 10, 25, 8, 12, 0};

        board = new();
        cycle_count  = 0;
        send_gap_pct = 0;
        stall_pct    = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = '0;
        position     = '0;
        item         = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every positional access rejects
        send_request(ACT_GET, 0, '0);
        send_request(ACT_ERASE, 0, '0);
        send_request(ACT_FIND, 0, '0);
        send_request(ACT_INSERT, 1, 32'h0000_0001);
        send_request(ACT_W'(5), 0, 32'hFFFF_FFFF);
        send_request(ACT_W'(7), 31, 32'hFFFF_FFFF);
        // build a short list at head and tail
        send_request(ACT_INSERT, 0, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 1, 32'h0000_0000);
        send_request(ACT_INSERT, 0, 32'h5A5A_A5A5);
        send_request(ACT_INSERT, 3, 32'h1234_5678);
        send_request(ACT_INSERT, 31, 32'hDEAD_BEEF);
        send_request(ACT_W'(6), 2, 32'h0);
        send_request(ACT_GET, 0, '0);
        send_request(ACT_GET, 3, '0);
        send_request(ACT_GET, 4, '0);
        send_request(ACT_FIND, 0, 32'h0000_0000);
        send_request(ACT_FIND, 0, 32'hDEAD_BEEF);
        send_request(ACT_ERASE, 3, '0);
        send_request(ACT_ERASE, 0, '0);
        send_request(ACT_ERASE, 5, '0);
        send_request(ACT_ERASE, 1, '0);
        send_request(ACT_CLEAR, 0, '0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_capacity(phase_cap[p]);
            send_gap_pct = phase_gap[p];
            stall_pct    = phase_stall[p];
            for (int k = 0; k < PHASE_REQS; k++)
                send_random(phase_insert[p]);
        end
        in_valid <= 1'b0;

        while (board.pending_replies.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);

        if (board.pending_replies.size() != 0)
        begin
            $display("%0d transactions never answered", board.pending_replies.size());
            board.errors++;
        end
        $display("Checked %0d responses over %0d capacity settings, %0d mismatching",
                 board.replies_checked, NUM_PHASES, board.errors);
        $display("Accepted/rejected: insert %0d/%0d erase %0d/%0d get %0d/%0d find %0d/%0d",
                 board.done_ok[ACT_INSERT], board.done_rejected[ACT_INSERT],
                 board.done_ok[ACT_ERASE], board.done_rejected[ACT_ERASE],
                 board.done_ok[ACT_GET], board.done_rejected[ACT_GET],
                 board.done_ok[ACT_FIND], board.done_rejected[ACT_FIND]);
        if (board.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
